// ===== src/sts_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package sts_pkg;

  localparam int STS_TABLE_DEPTH = 32;
  localparam int STS_DATA_W      = 32;
  localparam int STS_IDX_W       = 5;
  localparam int STS_SIZE_W      = 6;
  localparam int STS_PADDR_W     = 3;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Register indexes.
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic                         kind;
    logic [STS_IDX_W-1:0]         entry_index;
    logic signed [STS_DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [STS_IDX_W-1:0] position;
  } out_item_t;

endpackage

// ===== src/sts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sts_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sts_cfg.sv =====
// APB-style configuration register file holding the table size.
module sts_cfg
  import sts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [STS_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic [STS_SIZE_W-1:0]  table_size
);

  logic                  reg_idx;
  logic                  wr_en;
  logic [STS_SIZE_W-1:0] table_size_r;
  logic [STS_SIZE_W-1:0] table_size_nxt;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    table_size_nxt = table_size_r;
    if (wr_en && (reg_idx == REG_TABLE_SIZE)) begin
      table_size_nxt = pwdata[STS_SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TABLE_SIZE) begin
      prdata = {{(32-STS_SIZE_W){1'b0}}, table_size_r};
    end
  end

  assign pready     = 1'b1;
  assign table_size = table_size_r;

endmodule

// ===== src/sts_ctrl.sv =====
// Search sequencer: loads the table memory and walks it by halving, one probe a cycle.
module sts_ctrl
  import sts_pkg::*;
#(
  parameter int TABLE_DEPTH = STS_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic [STS_SIZE_W-1:0] table_size,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [STS_DATA_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  logic [STS_DATA_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic signed [STS_DATA_W-1:0] key_r, key_nxt;
  logic [STS_SIZE_W-1:0]        first_r, first_nxt;
  logic [STS_SIZE_W-1:0]        hi_r, hi_nxt;
  logic [STS_SIZE_W-1:0]        mid_r, mid_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_item_r, out_item_nxt;

  logic [STS_SIZE_W-1:0]        used;
  logic [STS_SIZE_W-1:0]        first_c;
  logic [STS_SIZE_W-1:0]        hi_c;
  logic [STS_SIZE_W:0]          mid_sum;
  logic [STS_SIZE_W-1:0]        mid_c;
  logic signed [STS_DATA_W-1:0] probe;
  logic                         probe_hit;
  logic                         probe_gt;

  // A size above the memory depth is clipped to the depth.
  assign used = (32'(table_size) > TABLE_DEPTH) ? STS_SIZE_W'(TABLE_DEPTH) : table_size;

  assign probe     = signed'(mem_rdata);
  assign probe_hit = (probe == key_r);
  assign probe_gt  = (probe > key_r);

  // The bounds for the next probe: [first, hi) with hi exclusive.
  always_comb begin
    first_c = first_r;
    hi_c    = hi_r;
    if (state_r == ST_IDLE) begin
      first_c = '0;
      hi_c    = used;
    end else if (probe_gt) begin
      hi_c = mid_r;
    end else begin
      first_c = mid_r + 1'b1;
    end
  end

  // Floor of (first + last) / 2 with last = hi - 1; only used on a nonempty range.
  assign mid_sum = {1'b0, first_c} + {1'b0, hi_c} - 1'b1;
  assign mid_c   = mid_sum[STS_SIZE_W:1];

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.kind == KIND_LOAD) begin
            mem_we = (32'(in_data.entry_index) < TABLE_DEPTH);
          end else if (hi_c == '0) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.found    = 1'b0;
            out_item_nxt.position = '0;
          end else begin
            state_nxt = ST_SEARCH;
            key_nxt   = in_data.value;
            first_nxt = first_c;
            hi_nxt    = hi_c;
            mid_nxt   = mid_c;
          end
        end
      end
      ST_SEARCH: begin
        if (probe_hit) begin
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          out_item_nxt.found    = 1'b1;
          out_item_nxt.position = mid_r[STS_IDX_W-1:0];
        end else if (first_c >= hi_c) begin
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          out_item_nxt.found    = 1'b0;
          out_item_nxt.position = '0;
        end else begin
          first_nxt = first_c;
          hi_nxt    = hi_c;
          mid_nxt   = mid_c;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    first_r    <= first_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    out_item_r <= out_item_nxt;
  end

  // Loads and probes never share a cycle, so the memory needs no forwarding.
  assign mem_waddr = ADDR_W'(in_data.entry_index);
  assign mem_wdata = in_data.value;
  assign mem_raddr = ADDR_W'(mid_c);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (first_r < hi_r))
    else $error("search range is empty while probing");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> ((mid_r >= first_r) && (mid_r < hi_r)))
    else $error("probe index outside the search range");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.found) |-> (out_item_r.position == '0))
    else $error("miss result carries a nonzero position");

  a_no_load_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("table write during a search");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_SEARCH && state_r == ST_IDLE) |-> out_valid_r)
    else $error("search finished without a result");

endmodule

// ===== src/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
//
//   Channel   Ports                          Transfer
//   input     start, busy, in_data           start && !busy at a rising edge
//   result    out_valid, out_data            one cycle with out_valid high
//   config    psel, penable, pwrite, paddr,  psel && penable && pwrite && pready
//             pwdata, prdata, pready
//
// A load is written straight into the table, keeps busy low and gives no result. A
// search issues its first read while idle and then probes in the search state, each
// probe waiting on the registered read of the single table memory. The result
// appears the cycle after the last probe, when busy has already dropped. Reset is
// synchronous and active low; it clears table_size and the sequencer but not the
// table. The result receiver cannot stall the block.
module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int TABLE_DEPTH = STS_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [STS_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [STS_SIZE_W-1:0] table_size;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [STS_DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [STS_DATA_W-1:0] mem_rdata;

  sts_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .table_size (table_size)
  );

  sts_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .table_size (table_size),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sts_ram #(
    .WIDTH  (STS_DATA_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== test/sorted_table_binary_search_tb.sv =====
// Self-checking testbench for the sorted table binary search block.
module sorted_table_binary_search_tb
  import sts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 750;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int WORD_MIN      = 32'sh8000_0000;
  localparam int WORD_MAX      = 32'sh7fff_ffff;
  localparam logic [STS_PADDR_W-1:0] TABLE_SIZE_ADDR = {REG_TABLE_SIZE, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_op_t;

  typedef struct {
    row_op_t               op;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
    logic [STS_SIZE_W-1:0] size;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  in_item_t               in_data;
  logic                   out_valid;
  out_item_t              out_data;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [STS_PADDR_W-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // Predictor state: its own copy of the table and of table_size.
  int                    tbl_words [STS_TABLE_DEPTH];
  logic [STS_SIZE_W-1:0] tbl_size;
  out_item_t             pending_lookups [$];
  stim_row_t             directed_rows [$];

  int   errors     = 0;
  int   n_loads    = 0;
  int   n_searches = 0;
  int   n_hits     = 0;
  int   n_settings = 0;
  logic idle_off   = 1'b0;

  logic [STS_SIZE_W-1:0] size_plan [8] = '{6'd32, 6'd63, 6'd1, 6'd2, 6'd33, 6'd31, 6'd0, 6'd16};

  sorted_table_binary_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one accepted item to the predictor; returns 1 when a result is due.
  function automatic logic predict_lookup(input in_item_t item, output out_item_t res);
    int used;
    int first;
    int last;
    int mid;
    int key;
    res = '0;
    if (item.kind == KIND_LOAD) begin
      tbl_words[item.entry_index] = int'(item.value);
      return 1'b0;
    end
    key   = int'(item.value);
    used  = (int'(tbl_size) > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : int'(tbl_size);
    first = 0;
    last  = used - 1;
    while (!res.found && first <= last) begin
      mid = (first + last) / 2;
      if (tbl_words[mid] == key) begin
        res.found    = 1'b1;
        res.position = STS_IDX_W'(mid);
      end else if (tbl_words[mid] > key) begin
        last = mid - 1;
      end else begin
        first = mid + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_load(input logic [STS_IDX_W-1:0] idx, input int val);
    stim_row_t row;
    row.op               = ROW_ITEM;
    row.item.kind        = KIND_LOAD;
    row.item.entry_index = idx;
    row.item.value       = val;
    row.typed            = 1'b0;
    row.want             = '0;
    row.size             = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_search(input logic [STS_IDX_W-1:0] idx, input int key,
                                     input logic typed, input logic found,
                                     input logic [STS_IDX_W-1:0] pos);
    stim_row_t row;
    row.op               = ROW_ITEM;
    row.item.kind        = KIND_SEARCH;
    row.item.entry_index = idx;
    row.item.value       = key;
    row.typed            = typed;
    row.want.found       = found;
    row.want.position    = pos;
    row.size             = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_size(input logic [STS_SIZE_W-1:0] size);
    stim_row_t row;
    row.op    = ROW_SIZE;
    row.item  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.size  = size;
    directed_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input in_item_t item, input logic typed, input out_item_t want);
    int        gap;
    out_item_t res;
    gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_lookup(item, res)) begin
      pending_lookups.push_back(typed ? want : res);
      n_searches++;
    end else begin
      n_loads++;
    end
    @(negedge clk);
  endtask

  // Writes table_size once the block is idle, then reads it back.
  task automatic write_table_size(input logic [STS_SIZE_W-1:0] size);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TABLE_SIZE_ADDR;
    pwdata  <= {26'($urandom), size};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tbl_size = size;
    n_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(size)) begin
      $display("%0t table_size readback: expected %0d, actual %0d", $time, size, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker: the receiver takes every strobed result.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t unexpected result: found %0b position %0d", $time,
                 out_data.found, out_data.position);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t found: expected %0b, actual %0b", $time, want.found, out_data.found);
          errors++;
        end
        if (out_data.position !== want.position) begin
          $display("%0t position: expected %0d, actual %0d", $time,
                   want.position, out_data.position);
          errors++;
        end
        if (out_data.found === 1'b1) n_hits++;
      end
    end
  end

  initial begin
    int        rand_items;
    int        phase;
    int        roll;
    int        used;
    int        key;
    int        span_bits;
    longint    acc;
    longint    step;
    in_item_t  item;
    logic [STS_SIZE_W-1:0] new_size;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tbl_size = '0;

    // Directed part: empty table after reset, extremes, unsorted contents.
    add_search(5'd0, 0, 1'b1, 1'b0, 5'd0);
    add_load(5'd0, WORD_MIN);
    add_load(5'd1, -1);
    add_load(5'd2, 0);
    add_load(5'd3, WORD_MAX);
    add_size(6'd4);
    add_search(5'd0, WORD_MIN, 1'b1, 1'b1, 5'd0);
    add_search(5'd31, WORD_MAX, 1'b1, 1'b1, 5'd3);
    add_search(5'd10, 0, 1'b0, 1'b0, 5'd0);
    add_search(5'd21, -1, 1'b0, 1'b0, 5'd0);
    add_search(5'd0, 1, 1'b1, 1'b0, 5'd0);
    add_search(5'd0, WORD_MAX - 1, 1'b0, 1'b0, 5'd0);
    add_load(5'd31, 32'sh5555_5555);
    add_load(5'd30, 32'shaaaa_aaaa);
    add_size(6'd1);
    add_search(5'd0, WORD_MIN, 1'b1, 1'b1, 5'd0);
    add_search(5'd0, -1, 1'b1, 1'b0, 5'd0);
    add_size(6'd3);
    // Entry 1 now breaks the ordering, so the key in entry 2 is missed.
    add_load(5'd1, 5);
    add_search(5'd0, 0, 1'b0, 1'b0, 5'd0);
    add_search(5'd0, 5, 1'b0, 1'b0, 5'd0);
    add_size(6'd0);
    add_search(5'd0, WORD_MIN, 1'b1, 1'b0, 5'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == ROW_SIZE) begin
        write_table_size(directed_rows[r].size);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random part: each phase sets table_size, mostly refills the table in
    // ascending order, then searches for table keys and others among stray loads.
    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS) begin
      new_size = (phase < 8) ? size_plan[phase] : STS_SIZE_W'($urandom_range(0, 63));
      write_table_size(new_size);
      idle_off = ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        span_bits = $urandom_range(0, 27);
        acc = ($urandom_range(0, 3) == 0) ? -64'sd2147483648
                                           : longint'($signed($urandom));
        for (int i = 0; i < STS_TABLE_DEPTH; i++) begin
          item.kind        = KIND_LOAD;
          item.entry_index = STS_IDX_W'(i);
          item.value       = acc[31:0];
          send_item(item, 1'b0, '0);
          step = $urandom_range(0, 1 << span_bits);
          acc  = acc + step;
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        end
        rand_items += STS_TABLE_DEPTH;
      end
      used = (int'(tbl_size) > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : int'(tbl_size);
      if (used == 0) used = STS_TABLE_DEPTH;
      repeat ($urandom_range(15, 40)) begin
        roll             = $urandom_range(0, 99);
        item.entry_index = STS_IDX_W'($urandom);
        if (roll < 12) begin
          // A stray load that may break the ordering.
          item.kind  = KIND_LOAD;
          item.value = $urandom;
        end else begin
          item.kind = KIND_SEARCH;
          key  = tbl_words[$urandom_range(0, used - 1)];
          roll = $urandom_range(0, 9);
          if (roll >= 9) begin
            case ($urandom_range(0, 3))
              0:       key = WORD_MIN;
              1:       key = WORD_MAX;
              2:       key = 0;
              default: key = -1;
            endcase
          end else if (roll >= 7) begin
            key = $urandom;
          end else if (roll >= 5) begin
            key = $urandom_range(0, 1) ? key + 1 : key - 1;
          end
          item.value = key;
        end
        send_item(item, 1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d loads and %0d searches (%0d matched) over %0d table_size writes.",
             n_loads, n_searches, n_hits, n_settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: the block stopped taking items or giving results.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
